// ===== sv/div64_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// div64_pkg: shared types and constants for the iterative divider
// Holds the operation select bit positions and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package div64_pkg;

  localparam int FUNC_W = 2;

  // Bit positions inside the operation select.
  localparam int FUNC_REM_BIT    = 0;
  localparam int FUNC_SIGNED_BIT = 1;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } div_cmd_t;

  typedef struct packed {
    logic div_zero;
  } div_status_t;

endpackage
`default_nettype wire

// ===== sv/div64_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// div64_ctrl: divider sequencing state machine
// Steps through operand preparation, one quotient bit per cycle and the sign
// fix-up, and raises the result strobe for one cycle at the end.
// ----------------------------------------------------------------------------
module div64_ctrl #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  output logic                           out_valid,
  output div64_pkg::div_cmd_t            cmd,
  input  wire div64_pkg::div_status_t    status
);
  import div64_pkg::*;

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIX  = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             valid_r;
  logic             valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    valid_nxt  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
        state_nxt = status.div_zero ? ST_FIX : ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.finish = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("transaction ended without a result strobe");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction did not start");

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a transaction is in progress");

endmodule
`default_nettype wire

// ===== sv/div64_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// div64_dp: divider datapath
// Holds the operands, takes magnitudes for signed operations, runs the
// restoring shift-subtract step and applies the sign to the chosen result.
// ----------------------------------------------------------------------------
module div64_dp #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                              clk,
  input  wire div64_pkg::div_cmd_t               cmd,
  output div64_pkg::div_status_t                 status,
  input  wire logic [div64_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [DATA_WIDTH-1:0]             in_dividend,
  input  wire logic [DATA_WIDTH-1:0]             in_divisor,
  output logic [DATA_WIDTH-1:0]                  result
);
  import div64_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [FUNC_W-1:0] func_r;
  logic [W-1:0]      quo_r;
  logic [W-1:0]      quo_nxt;
  logic [W-1:0]      dvs_r;
  logic [W-1:0]      dvs_nxt;
  logic [W-1:0]      rem_r;
  logic [W-1:0]      rem_nxt;
  logic [W-1:0]      res_r;
  logic [W-1:0]      res_nxt;
  logic              a_neg_r;
  logic              b_neg_r;
  logic              zero_r;
  logic              is_signed;
  logic [W+1:0]      diff;
  logic [W:0]        shifted;
  logic              qbit;
  logic [W-1:0]      pick;
  logic              neg_res;

  assign is_signed       = func_r[FUNC_SIGNED_BIT];
  assign status.div_zero = (dvs_r == '0);
  assign shifted         = {rem_r, quo_r[W-1]};
  assign diff            = {1'b0, shifted} - {2'b00, dvs_r};
  assign qbit            = ~diff[W+1];

  always_comb begin
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    res_nxt = res_r;
    pick    = func_r[FUNC_REM_BIT] ? rem_r : quo_r;
    neg_res = func_r[FUNC_REM_BIT] ? (is_signed && a_neg_r)
                                   : (is_signed && (a_neg_r != b_neg_r));
    if (cmd.load) begin
      quo_nxt = in_dividend;
      dvs_nxt = in_divisor;
    end else if (cmd.prep) begin
      rem_nxt = '0;
      if (is_signed && quo_r[W-1]) begin
        quo_nxt = '0 - quo_r;
      end
      if (is_signed && dvs_r[W-1]) begin
        dvs_nxt = '0 - dvs_r;
      end
    end else if (cmd.step) begin
      quo_nxt = {quo_r[W-2:0], qbit};
      rem_nxt = qbit ? diff[W-1:0] : shifted[W-1:0];
    end else if (cmd.finish) begin
      if (zero_r) begin
        res_nxt = '0;
      end else if (neg_res) begin
        res_nxt = '0 - pick;
      end else begin
        res_nxt = pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
    end
    if (cmd.prep) begin
      a_neg_r <= is_signed && quo_r[W-1];
      b_neg_r <= is_signed && dvs_r[W-1];
      zero_r  <= (dvs_r == '0);
    end
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule
`default_nettype wire

// ===== sv/divider_64_signed_unsigned.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// divider_64_signed_unsigned: iterative signed and unsigned integer divider
// Sequence: the preparation state takes the operand magnitudes, one
// shift-subtract step per quotient bit follows, then the sign fix-up state
// sets the result and the strobe is registered; a zero divisor skips the steps.
// A new transaction may be accepted in the cycle of the strobe, not before.
// The receiver cannot stall the result.
// Reset (rst_n, synchronous, active low) returns the controller to idle.
// ----------------------------------------------------------------------------
module divider_64_signed_unsigned #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [div64_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [63:0]                   in_dividend,
  input  wire logic [63:0]                   in_divisor,
  output logic                               out_valid,
  output logic [63:0]                        out_result
);
  import div64_pkg::*;

  div_cmd_t              cmd;
  div_status_t           status;
  logic [DATA_WIDTH-1:0] result;

  div64_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  div64_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .in_func     (in_func),
    .in_dividend (in_dividend[DATA_WIDTH-1:0]),
    .in_divisor  (in_divisor[DATA_WIDTH-1:0]),
    .result      (result)
  );

  assign out_result = 64'(result);

endmodule
`default_nettype wire
